@@ sv/ws2812_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the WS2812 pixel strip driver.
// No dependencies; every other file of the block imports this package.

package ws2812_pkg;

  // Pixel store geometry
  localparam int unsigned MaxPixels    = 1024;
  localparam int unsigned AddrW        = $clog2(MaxPixels);
  localparam int unsigned PixCntW      = 11;
  localparam int unsigned TickW        = 15;
  localparam int unsigned ColorW       = 8;
  localparam int unsigned PixW         = 3 * ColorW;
  localparam int unsigned BitsPerPixel = PixW;
  localparam int unsigned BitPosW      = $clog2(BitsPerPixel);
  localparam int unsigned CfgIdxW      = 3;

  // Register reset values
  localparam logic [PixCntW-1:0] PixelCountRst = PixCntW'(1);
  localparam logic [TickW-1:0]   ZeroHighRst   = TickW'(32);
  localparam logic [TickW-1:0]   ZeroLowRst    = TickW'(64);
  localparam logic [TickW-1:0]   OneHighRst    = TickW'(64);
  localparam logic [TickW-1:0]   OneLowRst     = TickW'(32);

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_SHOW  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_COUNT = 3'd0,
    CFG_ZERO_HIGH   = 3'd1,
    CFG_ZERO_LOW    = 3'd2,
    CFG_ONE_HIGH    = 3'd3,
    CFG_ONE_LOW     = 3'd4
  } cfg_e;

  // Request payload
  typedef struct packed {
    logic [2:0]        op;
    logic [9:0]        pixel_index;
    logic [ColorW-1:0] red_in;
    logic [ColorW-1:0] green_in;
    logic [ColorW-1:0] blue_in;
  } in_t;

  // Result payload
  typedef struct packed {
    logic              line_level;
    logic [ColorW-1:0] red_out;
    logic [ColorW-1:0] green_out;
    logic [ColorW-1:0] blue_out;
    logic [1:0]        status;
    logic              busy_res;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch request, clear result
    logic tick;        // advance waveform one tick
    logic wr_pixel;    // write request color
    logic mem_rd;      // issue store read
    logic sweep_wr;    // write zero at sweep address
    logic sweep_full;  // sweep covers whole store
    logic show_start;  // begin frame
    logic load_pixel;  // load shifter from read data
    logic rd_capture;  // read data into result
    logic err_range;
    logic err_busy;
    logic out_load;    // fill output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       sending;
    logic       in_range;
    logic       needs_load;
    logic       pix_none;
    logic       sweep_full_last;
    logic       sweep_used_last;
  } stat_t;

endpackage

@@ sv/ws2812_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: config registers, pixel store, waveform counters, result register.
// Depends on ws2812_pkg; driven by ws2812_ctrl commands.

module ws2812_dpath import ws2812_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  in_t                in_req_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  output out_t               out_rsp_o
);

  localparam logic [BitPosW-1:0] LastBit = BitPosW'(BitsPerPixel - 1);

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

  // Config registers
  logic [PixCntW-1:0] pixel_count_q;
  logic [TickW-1:0]   zero_high_q, zero_low_q, one_high_q, one_low_q;

  // Waveform state
  logic               sending_q;
  logic [AddrW-1:0]   ptr_q;
  logic [BitPosW-1:0] bit_q;
  logic               low_q;
  logic [TickW-1:0]   ticks_q;
  logic [PixW-1:0]    shift_q;
  logic [AddrW-1:0]   sweep_q;

  // Request and result
  in_t                req_q;
  logic [PixW-1:0]    res_rgb_q;
  status_e            res_status_q;
  out_t               out_q;

  // Pixel store, {red, green, blue} per entry
  logic [PixW-1:0]    mem [MaxPixels];
  logic [PixW-1:0]    rdata_q;

  logic [PixCntW-1:0] n_used;
  logic [PixCntW-1:0] ptr_inc;
  logic [TickW-1:0]   ticks_dec;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [PixW-1:0]    wr_data;
  logic               mem_we;
  logic               sweep_full_last, sweep_used_last;

  // Pixels in use, clamped to the store size
  assign n_used  = (pixel_count_q > PixCntW'(MaxPixels)) ? PixCntW'(MaxPixels) : pixel_count_q;
  assign ptr_inc = PixCntW'(ptr_q) + PixCntW'(1);
  assign ticks_dec = (ticks_q != '0) ? ticks_q - TickW'(1) : '0;

  assign sweep_full_last = (sweep_q == AddrW'(MaxPixels - 1));
  assign sweep_used_last = (PixCntW'(sweep_q) == n_used - PixCntW'(1));

  // Status to controller
  always_comb begin
    stat_o.op              = req_q.op;
    stat_o.sending         = sending_q;
    stat_o.in_range        = (PixCntW'(req_q.pixel_index) < n_used);
    stat_o.needs_load      = sending_q && (ticks_dec == '0) && low_q &&
                             (bit_q == LastBit) && (ptr_inc < n_used);
    stat_o.pix_none        = (n_used == '0);
    stat_o.sweep_full_last = sweep_full_last;
    stat_o.sweep_used_last = sweep_used_last;
  end

  // Store port selection
  always_comb begin
    case (req_q.op)
      OP_READ: rd_addr = req_q.pixel_index[AddrW-1:0];
      OP_SHOW: rd_addr = '0;
      default: rd_addr = ptr_inc[AddrW-1:0];
    endcase
  end

  assign mem_we  = cmd_i.wr_pixel | cmd_i.sweep_wr;
  assign wr_addr = cmd_i.sweep_wr ? sweep_q : req_q.pixel_index[AddrW-1:0];
  assign wr_data = cmd_i.sweep_wr ? '0 : {req_q.red_in, req_q.green_in, req_q.blue_in};

  // Pixel store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= PixelCountRst;
      zero_high_q   <= ZeroHighRst;
      zero_low_q    <= ZeroLowRst;
      one_high_q    <= OneHighRst;
      one_low_q     <= OneLowRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXEL_COUNT: pixel_count_q <= cfg_data_i[PixCntW-1:0];
        CFG_ZERO_HIGH:   zero_high_q   <= cfg_data_i;
        CFG_ZERO_LOW:    zero_low_q    <= cfg_data_i;
        CFG_ONE_HIGH:    one_high_q    <= cfg_data_i;
        CFG_ONE_LOW:     one_low_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Waveform state and sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      ptr_q     <= '0;
      bit_q     <= '0;
      low_q     <= 1'b0;
      ticks_q   <= '0;
      shift_q   <= '0;
      sweep_q   <= '0;
    end else begin
      if (cmd_i.sweep_wr) begin
        if (cmd_i.sweep_full ? sweep_full_last : sweep_used_last) begin
          sweep_q <= '0;
        end else begin
          sweep_q <= sweep_q + AddrW'(1);
        end
      end

      if (cmd_i.show_start) begin
        sending_q <= 1'b1;
        ptr_q     <= '0;
      end else if (cmd_i.load_pixel) begin
        // shifter holds green, red, blue
        shift_q <= {rdata_q[15:8], rdata_q[23:16], rdata_q[7:0]};
        bit_q   <= '0;
        low_q   <= 1'b0;
        ticks_q <= at_least_one(rdata_q[15] ? one_high_q : zero_high_q);
      end else if (cmd_i.tick && sending_q) begin
        if (ticks_dec != '0) begin
          ticks_q <= ticks_dec;
        end else if (!low_q) begin
          low_q   <= 1'b1;
          ticks_q <= at_least_one(shift_q[PixW-1] ? one_low_q : zero_low_q);
        end else if (bit_q == LastBit) begin
          // pixel done; next pixel arrives through load_pixel
          ptr_q   <= ptr_inc[AddrW-1:0];
          shift_q <= shift_q << 1;
          if (ptr_inc >= n_used) begin
            sending_q <= 1'b0;
            low_q     <= 1'b0;
            ticks_q   <= '0;
            bit_q     <= '0;
          end
        end else begin
          bit_q   <= bit_q + BitPosW'(1);
          shift_q <= shift_q << 1;
          low_q   <= 1'b0;
          ticks_q <= at_least_one(shift_q[PixW-2] ? one_high_q : zero_high_q);
        end
      end
    end
  end

  // Request latch and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q        <= in_req_i;
      res_rgb_q    <= '0;
      res_status_q <= ST_OK;
    end else begin
      if (cmd_i.rd_capture) res_rgb_q    <= rdata_q;
      if (cmd_i.err_range)  res_status_q <= ST_RANGE;
      if (cmd_i.err_busy)   res_status_q <= ST_BUSY;
    end
    if (cmd_i.out_load) begin
      out_q.line_level <= sending_q & ~low_q;
      out_q.red_out    <= res_rgb_q[23:16];
      out_q.green_out  <= res_rgb_q[15:8];
      out_q.blue_out   <= res_rgb_q[7:0];
      out_q.status     <= res_status_q;
      out_q.busy_res   <= sending_q;
    end
  end

  assign out_rsp_o = out_q;

endmodule

@@ sv/ws2812_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences each request through the datapath and owns the
// request and result handshakes. Depends on ws2812_pkg.

module ws2812_ctrl import ws2812_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_RDWAIT,
    S_CLEAR,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        // zero the whole store after reset
        cmd_o.sweep_wr   = 1'b1;
        cmd_o.sweep_full = 1'b1;
        if (stat_i.sweep_full_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        if (stat_i.sending &&
            stat_i.op inside {OP_WRITE, OP_READ, OP_CLEAR, OP_SHOW}) begin
          cmd_o.err_busy = 1'b1;
        end else begin
          case (stat_i.op)
            OP_TICK: begin
              cmd_o.tick = 1'b1;
              if (stat_i.needs_load) begin
                cmd_o.mem_rd = 1'b1;
                state_d      = S_LOAD;
              end
            end
            OP_WRITE: begin
              if (stat_i.in_range) cmd_o.wr_pixel  = 1'b1;
              else                 cmd_o.err_range = 1'b1;
            end
            OP_READ: begin
              if (stat_i.in_range) begin
                cmd_o.mem_rd = 1'b1;
                state_d      = S_RDWAIT;
              end else begin
                cmd_o.err_range = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (!stat_i.pix_none) state_d = S_CLEAR;
            end
            OP_SHOW: begin
              if (!stat_i.pix_none) begin
                cmd_o.show_start = 1'b1;
                cmd_o.mem_rd     = 1'b1;
                state_d          = S_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_pixel = 1'b1;
        state_d          = S_RESP;
      end
      S_RDWAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_RESP;
      end
      S_CLEAR: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_used_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

@@ sv/ws2812_pixel_strip_driver_unit.sv @@
`timescale 1ns / 1ps
// Top level of the WS2812 pixel strip driver.
// Depends on ws2812_pkg, ws2812_ctrl and ws2812_dpath.
//
//   channel   direction  handshake                 payload
//   request   in         in_valid_i / in_ready_o   in_req_i (in_t)
//   result    out        out_valid_o / out_ready_i out_rsp_o (out_t)
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time. Each passes from accept through S_EXEC to S_RESP;
// an in-range read, a show and a tick that starts a new pixel also pass
// S_RDWAIT or S_LOAD (the pixel store read is registered); a clear-all
// passes S_CLEAR. After reset the store is zeroed with in_ready_o low;
// config writes are taken at any time. A result waiting in the output
// register does not block the next accept, only the next result.

module ws2812_pixel_strip_driver_unit import ws2812_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  ws2812_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ws2812_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ sv/ws2812_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the WS2812 pixel strip driver, bound to the top.
// Depends on ws2812_pkg and ws2812_pixel_strip_driver_unit.

module ws2812_chk import ws2812_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input in_t                in_req_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_t               out_rsp_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [TickW-1:0]   cfg_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // only one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  // line can only be high during a frame
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.line_level |-> out_rsp_o.busy_res)
    else $error("line high while idle");

  // read-back colors only on an accepted read
  a_color_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.red_out != '0 || out_rsp_o.green_out != '0 ||
                    out_rsp_o.blue_out != '0)
    |-> out_rsp_o.status == ST_OK && !out_rsp_o.busy_res)
    else $error("color returned with error or while busy");

  // status code is never the unused value
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status == ST_OK || out_rsp_o.status == ST_RANGE ||
                    out_rsp_o.status == ST_BUSY)
    else $error("bad status code");

endmodule

bind ws2812_pixel_strip_driver_unit ws2812_chk u_chk (.*);
